// File: rtl/vt4_pkg.sv
// Shared types and constants for the 4x4 vertex transform engine.
package vt4_pkg;

   localparam int DIM       = 4;
   localparam int NUM_WORDS = DIM * DIM;
   localparam int IDX_W     = $clog2(NUM_WORDS);
   localparam int DATA_W    = 32;
   localparam int Q_SHIFT   = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int TERM_W    = PROD_W - Q_SHIFT;
   localparam int SUM_W     = TERM_W + $clog2(DIM);

   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_VECTOR = 2'd1,
      OP_POINT  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic [IDX_W-1:0]         index_type;

   typedef word_type matrix_type [NUM_WORDS];
   typedef word_type vec_type    [DIM];
   typedef term_type terms_type  [DIM][DIM];

   // Control that travels alongside the data through each pipeline stage
   typedef struct packed {
      logic valid;
      logic point;
   } stage_ctl_type;

endpackage

// File: rtl/vt4_ifs.sv
// Request and response channel interfaces of the vertex transform engine.
interface vt4_req_if import vt4_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    op;
   index_type word_index;
   word_type  word_value;
   word_type  vec_x;
   word_type  vec_y;
   word_type  vec_z;
   word_type  vec_w;

   modport source (output valid, op, word_index, word_value, vec_x, vec_y, vec_z, vec_w,
                   input ready);
   modport sink   (input valid, op, word_index, word_value, vec_x, vec_y, vec_z, vec_w,
                   output ready);
endinterface

interface vt4_rsp_if import vt4_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type res_x;
   word_type res_y;
   word_type res_z;
   word_type res_w;
   logic     was_point;

   modport source (output valid, res_x, res_y, res_z, res_w, was_point, input ready);
   modport sink   (input valid, res_x, res_y, res_z, res_w, was_point, output ready);
endinterface

// File: rtl/vt4_matrix_regs.sv
// Matrix word store: sixteen Q16.16 words, one write port, every word visible.
module vt4_matrix_regs import vt4_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       write_en,
   input  index_type  write_index,
   input  word_type   write_value,
   output matrix_type matrix
);

   matrix_type words_ff;
   matrix_type words_in;

   // Next value: one word replaced on a load
   always_comb begin
      words_in = words_ff;
      if (write_en) begin
         words_in[write_index] = write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_WORDS; k++) begin
            words_ff[k] <= '0;
         end
      end else begin
         words_ff <= words_in;
      end
   end

   assign matrix = words_ff;

endmodule

// File: rtl/vt4_product_stage.sv
// Product stage: sixteen Q16.16 multiplies, floor-shifted and registered.
module vt4_product_stage import vt4_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  stage_ctl_type ctl,
   input  vec_type       vec,
   input  matrix_type    matrix,
   output stage_ctl_type ctl_out,
   output terms_type     terms
);

   stage_ctl_type ctl_ff;
   terms_type     terms_ff;
   terms_type     terms_in;

   // One multiplier per matrix word; the bottom row is the raw word for a point
   for (genvar i = 0; i < DIM; i++) begin : g_row
      for (genvar j = 0; j < DIM; j++) begin : g_col
         logic signed [PROD_W-1:0] prod;

         assign prod = PROD_W'($signed(vec[i])) * PROD_W'($signed(matrix[i*DIM+j]));

         if (i == DIM - 1) begin : g_last
            assign terms_in[i][j] = ctl.point ? TERM_W'(matrix[i*DIM+j])
                                              : prod[PROD_W-1:Q_SHIFT];
         end else begin : g_body
            assign terms_in[i][j] = prod[PROD_W-1:Q_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         terms_ff <= terms_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign terms   = terms_ff;

endmodule

// File: rtl/vt4_sum_stage.sv
// Sum stage: column sums, saturation to 32 bits and the response register.
module vt4_sum_stage import vt4_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  terms_type     terms,
   output logic          ready,
   vt4_rsp_if.source     rsp_if
);

   logic     valid_ff;
   logic     point_ff;
   vec_type  res_ff;
   vec_type  res_in;

   // Exact column sum, clamped once
   for (genvar j = 0; j < DIM; j++) begin : g_col
      logic signed [SUM_W-1:0] sum;

      assign sum = SUM_W'(terms[0][j]) + SUM_W'(terms[1][j])
                 + SUM_W'(terms[2][j]) + SUM_W'(terms[3][j]);

      always_comb begin
         if (j == DIM - 1 && ctl.point) begin
            res_in[j] = '0;
         end else if (sum > SUM_MAX) begin
            res_in[j] = SUM_MAX[DATA_W-1:0];
         end else if (sum < SUM_MIN) begin
            res_in[j] = SUM_MIN[DATA_W-1:0];
         end else begin
            res_in[j] = sum[DATA_W-1:0];
         end
      end
   end

   assign ready = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         point_ff <= ctl.point;
         res_ff   <= res_in;
      end
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.res_x     = res_ff[0];
   assign rsp_if.res_y     = res_ff[1];
   assign rsp_if.res_z     = res_ff[2];
   assign rsp_if.res_w     = res_ff[3];
   assign rsp_if.was_point = point_ff;

endmodule

// File: rtl/vector_transform_4x4.sv
// Top level of the 4x4 Q16.16 vertex transform engine.
//
//   channel   port      direction   carries
//   request   req_if    in          load word / transform vector / transform point
//   response  rsp_if    out         transformed components and point flag
//
// Three stages: input register, product register, response register.
// One request per cycle while no stalled response has backed up to the input. A
// transform passes through the input, product and response registers in order.
// Loads write the matrix at the edge they are taken, no response.
// Reset clears the matrix to zero and empties the pipeline.
// A stalled response backs up stage by stage; empty stages still take requests.
module vector_transform_4x4 import vt4_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   vt4_req_if.sink   req_if,
   vt4_rsp_if.source rsp_if
);

   stage_ctl_type s1_ctl_ff;
   stage_ctl_type s1_ctl_in;
   vec_type       s1_vec_ff;
   stage_ctl_type s2_ctl;
   terms_type     s2_terms;
   matrix_type    matrix;
   logic          s1_ready;
   logic          s2_ready;
   logic          s3_ready;
   logic          accept;
   logic          is_load;
   logic          is_xform;
   logic          matrix_we;

   // Request decode
   always_comb begin
      is_load  = 1'b0;
      is_xform = 1'b0;
      unique case (req_if.op) inside
         OP_LOAD:              is_load  = 1'b1;
         OP_VECTOR, OP_POINT:  is_xform = 1'b1;
         default:              ;
      endcase
   end

   // Stage handshake: each stage moves when it is empty or its successor moves
   assign s2_ready     = !s2_ctl.valid || s3_ready;
   assign s1_ready     = !s1_ctl_ff.valid || s2_ready;
   assign req_if.ready = s1_ready;
   assign accept       = req_if.valid && s1_ready;
   assign matrix_we    = accept && is_load;

   assign s1_ctl_in.valid = accept && is_xform;
   assign s1_ctl_in.point = req_if.op == OP_POINT;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (s1_ready) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_vec_ff[0] <= req_if.vec_x;
         s1_vec_ff[1] <= req_if.vec_y;
         s1_vec_ff[2] <= req_if.vec_z;
         s1_vec_ff[3] <= req_if.vec_w;
      end
   end

   vt4_matrix_regs u_matrix (
      .clock       (clock),
      .reset       (reset),
      .write_en    (matrix_we),
      .write_index (req_if.word_index),
      .write_value (req_if.word_value),
      .matrix      (matrix)
   );

   vt4_product_stage u_product (
      .clock   (clock),
      .reset   (reset),
      .advance (s2_ready),
      .ctl     (s1_ctl_ff),
      .vec     (s1_vec_ff),
      .matrix  (matrix),
      .ctl_out (s2_ctl),
      .terms   (s2_terms)
   );

   vt4_sum_stage u_sum (
      .clock  (clock),
      .reset  (reset),
      .ctl    (s2_ctl),
      .terms  (s2_terms),
      .ready  (s3_ready),
      .rsp_if (rsp_if)
   );

`ifndef ASSERT_OFF
   // A transform waiting for its products must never see the matrix change
   a_no_load_under_stall: assert property (@(posedge clock) disable iff (reset)
      s1_ctl_ff.valid && !s2_ready |-> !matrix_we)
      else $error("matrix written while a transform waits in the input register");

   // Loads and unused codes never enter the pipeline
   a_no_entry_for_load: assert property (@(posedge clock) disable iff (reset)
      accept && (req_if.op == OP_LOAD || req_if.op == OP_UNUSED) |=> !s1_ctl_ff.valid)
      else $error("non-transform request entered the pipeline");

   // A point response carries a zero fourth component
   a_point_w_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.was_point |-> rsp_if.res_w == '0)
      else $error("point response with non-zero w");
`endif

endmodule

// File: tb/sv/tb_vector_transform_4x4.sv
// Self-checking testbench for the 4x4 Q16.16 vertex transform engine.
module tb_vector_transform_4x4;
   timeunit 1ns;
   timeprecision 1ps;

   import vt4_pkg::*;

   localparam word_type W_MAX = 32'h7fff_ffff;
   localparam word_type W_MIN = 32'h8000_0000;
   localparam word_type W_ONE = 32'h0001_0000;
   localparam int RANDOM_ITEMS = 900;

   typedef struct {
      op_type    op;
      index_type word_index;
      word_type  word_value;
      word_type  vec_x;
      word_type  vec_y;
      word_type  vec_z;
      word_type  vec_w;
      int        gap;     // idle cycles before this request is offered
      bit        drain;   // hold this request until no response is outstanding
   } vertex_req_type;

   typedef struct {
      word_type res_x;
      word_type res_y;
      word_type res_z;
      word_type res_w;
      logic     was_point;
   } vertex_rsp_type;

   logic clock;
   logic reset;

   vt4_req_if req_bus();
   vt4_rsp_if rsp_bus();

   vector_transform_4x4 i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   vertex_req_type pending_reqs [$];
   vertex_rsp_type expected_rsps [$];
   word_type       matrix_model [NUM_WORDS];

   int offered_count = 0;
   int taken_count   = 0;
   int rsp_count     = 0;
   int item_total    = 0;
   int error_count   = 0;
   int burst_left    = 0;

   vertex_req_type next_req;
   bit             next_loaded = 1'b0;
   int             gap_left    = 0;

   int seen_rsps  = 0;
   int stall_left = 0;
   int quiet_left = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Q16.16 product, floor of the full product over 2^16
   function automatic logic signed [63:0] q_product(word_type a, word_type b);
      logic signed [63:0] wide_a;
      logic signed [63:0] wide_b;
      wide_a = a;
      wide_b = b;
      return (wide_a * wide_b) >>> Q_SHIFT;
   endfunction

   function automatic word_type clamp_word(logic signed [63:0] s);
      if (s > 64'sd2147483647) return W_MAX;
      if (s < -64'sd2147483648) return W_MIN;
      return s[DATA_W-1:0];
   endfunction

   // Expected response of a transform request against the current matrix copy
   function automatic vertex_rsp_type transform_vertex(vertex_req_type r);
      vertex_rsp_type     rsp;
      word_type           comp [DIM];
      word_type           res [DIM];
      logic signed [63:0] s;
      comp = '{r.vec_x, r.vec_y, r.vec_z, r.vec_w};
      for (int j = 0; j < DIM; j++) begin
         s = q_product(comp[0], matrix_model[j])
           + q_product(comp[1], matrix_model[4 + j])
           + q_product(comp[2], matrix_model[8 + j]);
         if (r.op == OP_VECTOR) begin
            s = s + q_product(comp[3], matrix_model[12 + j]);
         end else if (j < 3) begin
            s = s + matrix_model[12 + j];
         end else begin
            s = 0;
         end
         res[j] = clamp_word(s);
      end
      rsp.res_x     = res[0];
      rsp.res_y     = res[1];
      rsp.res_z     = res[2];
      rsp.res_w     = res[3];
      rsp.was_point = (r.op == OP_POINT);
      return rsp;
   endfunction

   // Mix of extremes, unit values, small magnitudes and full-range words
   function automatic word_type pick_word();
      case ($urandom_range(0, 11))
         0: return W_MAX;
         1: return W_MIN;
         2: return '0;
         3: return W_ONE;
         4: return -W_ONE;
         5: return word_type'(1);
         6: return word_type'(-1);
         7, 8, 9: return word_type'($urandom_range(0, 32'h000f_ffff)) - word_type'(32'h0008_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_req(op_type op, int idx, word_type value, word_type x, word_type y,
                          word_type z, word_type w, bit drain);
      vertex_req_type r;
      r.op         = op;
      r.word_index = index_type'(idx);
      r.word_value = value;
      r.vec_x      = x;
      r.vec_y      = y;
      r.vec_z      = z;
      r.vec_w      = w;
      r.drain      = drain;
      // occasional stretches of back-to-back requests
      if (burst_left > 0) begin
         burst_left--;
         r.gap = 0;
      end else begin
         r.gap = $urandom_range(0, 10);
         if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
      end
      pending_reqs.push_back(r);
   endtask

   task automatic report_mismatch(string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // Request driver: one request held until taken, then the next after its gap
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && taken_count != offered_count)) begin
         if (!next_loaded && pending_reqs.size() != 0) begin
            next_req    = pending_reqs.pop_front();
            next_loaded = 1'b1;
            gap_left    = next_req.gap;
         end
         if (!next_loaded) begin
            req_bus.valid <= 1'b0;
         end else if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
         end else if (next_req.drain && expected_rsps.size() != 0) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.op         <= next_req.op;
            req_bus.word_index <= next_req.word_index;
            req_bus.word_value <= next_req.word_value;
            req_bus.vec_x      <= next_req.vec_x;
            req_bus.vec_y      <= next_req.vec_y;
            req_bus.vec_z      <= next_req.vec_z;
            req_bus.vec_w      <= next_req.vec_w;
            req_bus.valid      <= 1'b1;
            next_loaded = 1'b0;
            offered_count++;
         end
      end
   end

   // Response sink: a fresh stall drawn after every response taken, none in quiet stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (seen_rsps != rsp_count) begin
            seen_rsps = rsp_count;
            if (quiet_left > 0) begin
               quiet_left--;
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, 10);
               if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(15, 50);
            end
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: check responses, then predict from requests taken at this edge
   always @(posedge clock) begin
      vertex_req_type seen;
      vertex_rsp_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_bus.res_x !== want.res_x)
                  report_mismatch($sformatf("res_x expected %h got %h", want.res_x, rsp_bus.res_x));
               if (rsp_bus.res_y !== want.res_y)
                  report_mismatch($sformatf("res_y expected %h got %h", want.res_y, rsp_bus.res_y));
               if (rsp_bus.res_z !== want.res_z)
                  report_mismatch($sformatf("res_z expected %h got %h", want.res_z, rsp_bus.res_z));
               if (rsp_bus.res_w !== want.res_w)
                  report_mismatch($sformatf("res_w expected %h got %h", want.res_w, rsp_bus.res_w));
               if (rsp_bus.was_point !== want.was_point)
                  report_mismatch($sformatf("was_point expected %b got %b",
                                            want.was_point, rsp_bus.was_point));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken_count++;
            seen.op         = req_bus.op;
            seen.word_index = req_bus.word_index;
            seen.word_value = req_bus.word_value;
            seen.vec_x      = req_bus.vec_x;
            seen.vec_y      = req_bus.vec_y;
            seen.vec_z      = req_bus.vec_z;
            seen.vec_w      = req_bus.vec_w;
            case (seen.op) inside
               OP_LOAD:   matrix_model[seen.word_index] = seen.word_value;
               OP_VECTOR,
               OP_POINT:  expected_rsps.push_back(transform_vertex(seen));
               default:   ;
            endcase
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int     counted;
      int     sel;
      op_type pick_op;
      bit     hold;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_LOAD;
      req_bus.word_index = '0;
      req_bus.word_value = '0;
      req_bus.vec_x      = '0;
      req_bus.vec_y      = '0;
      req_bus.vec_z      = '0;
      req_bus.vec_w      = '0;
      rsp_bus.ready      = 1'b0;
      for (int k = 0; k < NUM_WORDS; k++) matrix_model[k] = '0;

      // matrix cleared by reset
      add_req(OP_VECTOR, 0, 0, W_MIN, W_MIN, W_MIN, W_MIN, 0);
      add_req(OP_POINT, 0, 0, W_MAX, W_MAX, W_MAX, W_MIN, 0);
      add_req(OP_UNUSED, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
              $urandom, 0);
      // identity
      add_req(OP_LOAD, 0, W_ONE, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_LOAD, 5, W_ONE, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_LOAD, 10, W_ONE, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_LOAD, 15, W_ONE, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_VECTOR, 0, 0, 32'h0001_8000, 32'hfffe_0000, W_MAX, W_MIN, 0);
      add_req(OP_POINT, 0, 0, 32'h0003_0000, -W_ONE, 32'h0000_0001, W_MAX, 0);
      // extreme translation row
      add_req(OP_LOAD, 12, W_MAX, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_LOAD, 13, W_MIN, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_LOAD, 14, word_type'(-1), $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_POINT, 0, 0, 0, 0, 0, W_MIN, 0);
      add_req(OP_POINT, 0, 0, W_MAX, W_MIN, W_MAX, 0, 0);
      // saturation both ways
      add_req(OP_LOAD, 0, W_MAX, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_VECTOR, 0, 0, W_MAX, 0, 0, 0, 0);
      add_req(OP_VECTOR, 0, 0, W_MIN, 0, 0, 0, 0);
      add_req(OP_LOAD, 5, W_MIN, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_VECTOR, 0, 0, 0, W_MIN, 0, 0, 0);
      // small negative product rounds down
      add_req(OP_LOAD, 10, word_type'(1), $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_VECTOR, 0, 0, 0, 0, word_type'(-1), 0, 0);
      // unused op must not write the matrix; sender waits for the pipeline to empty
      add_req(OP_UNUSED, 10, W_MAX, $urandom, $urandom, $urandom, $urandom, 0);
      add_req(OP_VECTOR, 0, 0, 0, 0, word_type'(-1), 0, 1);

      // random part: single requests plus occasional whole-matrix reloads
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) begin
            for (int k = 0; k < NUM_WORDS; k++)
               add_req(OP_LOAD, k, pick_word(), $urandom, $urandom, $urandom, $urandom, 0);
            counted += NUM_WORDS;
         end else begin
            sel  = $urandom_range(0, 99);
            hold = ($urandom_range(0, 49) == 0);
            if (sel < 25) pick_op = OP_LOAD;
            else if (sel < 60) pick_op = OP_VECTOR;
            else if (sel < 95) pick_op = OP_POINT;
            else pick_op = OP_UNUSED;
            add_req(pick_op, $urandom_range(0, 15), pick_word(), pick_word(), pick_word(),
                    pick_word(), pick_word(), hold);
            if (pick_op != OP_UNUSED) counted++;
         end
      end
      item_total = pending_reqs.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (taken_count != item_total) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
